// ----- design/duet_pkg.sv -----
// ---------------------------------------------------------------------------
// duet_pkg
// Shared types and constants for the duet instruction execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package duet_pkg;

    localparam int DEFAULT_REGISTER_COUNT = 26;
    localparam int REG_P                  = 15;
    localparam int CFG_INDEX_W            = 8;
    localparam int CFG_DATA_W             = 8;
    localparam int STEP_COUNT             = 64;

    // operation codes
    localparam logic [2:0] OP_SET = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_MOD = 3'd3;
    localparam logic [2:0] OP_JGZ = 3'd4;
    localparam logic [2:0] OP_SND = 3'd5;
    localparam logic [2:0] OP_RCV = 3'd6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CORE_ID = 8'd1;

    typedef struct packed {
        logic [2:0]         operation;
        logic               x_is_reg;
        logic [4:0]         x_reg;
        logic signed [31:0] x_imm;
        logic               y_is_reg;
        logic [4:0]         y_reg;
        logic signed [31:0] y_imm;
        logic               receive_valid;
        logic signed [63:0] receive_value;
    } duet_in_t;

    typedef struct packed {
        logic signed [63:0] pc_delta;
        logic               send_valid;
        logic signed [63:0] send_value;
        logic               receive_taken;
        logic               waiting;
        logic               recovered;
        logic signed [63:0] recovered_value;
        logic [31:0]        send_count;
        logic               fault;
    } duet_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_X,
        ST_RD_Y,
        ST_EXEC,
        ST_ALU,
        ST_RESULT
    } duet_state_t;

    typedef struct packed {
        logic start;
        logic is_mod;
    } duet_alu_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } duet_alu_stat_t;

endpackage

`default_nettype wire

// ----- design/duet_ram.sv -----
// ---------------------------------------------------------------------------
// duet_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module duet_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 26
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/duet_alu.sv -----
// ---------------------------------------------------------------------------
// duet_alu
// Iterative multiply and truncating modulo over one shared 65-bit adder,
// one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module duet_alu (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire duet_pkg::duet_alu_ctrl_t ctrl,
    input  wire logic [63:0]              a,
    input  wire logic [63:0]              b,
    output duet_pkg::duet_alu_stat_t      stat,
    output logic [63:0]                   result
);
    import duet_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        is_mod_reg, is_mod_next;
    logic        neg_reg, neg_next;
    logic [63:0] acc_reg, acc_next;     // product or remainder
    logic [63:0] opa_reg, opa_next;     // multiplicand or dividend
    logic [63:0] opb_reg, opb_next;     // multiplier or divisor

    logic [64:0] add_a, add_b, add_sum;
    logic        add_sub;

    // shared adder
    always_comb begin
        if (is_mod_reg) begin
            add_a   = {acc_reg, opa_reg[63]};
            add_b   = {1'b0, opb_reg};
            add_sub = 1'b1;
        end else begin
            add_a   = {1'b0, acc_reg};
            add_b   = {1'b0, opb_reg[0] ? opa_reg : 64'd0};
            add_sub = 1'b0;
        end
        add_sum = add_a + (add_sub ? ~add_b : add_b) + 65'(add_sub);
    end

    // sequencing
    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        is_mod_next = is_mod_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        if (ctrl.start && !busy_reg) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            is_mod_next = ctrl.is_mod;
            acc_next    = '0;
            if (ctrl.is_mod) begin
                neg_next = a[63];
                opa_next = a[63] ? (64'd0 - a) : a;
                opb_next = b[63] ? (64'd0 - b) : b;
            end else begin
                neg_next = 1'b0;
                opa_next = a;
                opb_next = b;
            end
        end else if (busy_reg) begin
            if (is_mod_reg) begin
                acc_next = add_sum[64] ? add_a[63:0] : add_sum[63:0];
                opa_next = {opa_reg[62:0], 1'b0};
            end else begin
                acc_next = add_sum[63:0];
                opa_next = {opa_reg[62:0], 1'b0};
                opb_next = {1'b0, opb_reg[63:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(STEP_COUNT - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        is_mod_reg <= is_mod_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (is_mod_reg && neg_reg) ? (64'd0 - acc_reg) : acc_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("alu done while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg)) else $error("alu done without work");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !$past(busy_reg) |-> cnt_reg == 6'd0) else $error("alu count not cleared");
`endif

endmodule

`default_nettype wire

// ----- design/duet_instruction_execute_unit.sv -----
// ---------------------------------------------------------------------------
// duet_instruction_execute_unit
// Executes one decoded duet instruction per input word against a
// register file held in a RAM.
// ---------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one decoded instruction word; m_valid/m_ready/
//   m_data deliver exactly one result word for it. cfg_valid/cfg_ready/
//   cfg_index/cfg_data write mode (index 0) and core_id (index 1); a core_id
//   write also loads register p. cfg_ready is always high; write only while
//   the unit is idle.
//   After accept, the unit reads register x, then register y, executes and
//   registers the result; mul and mod (but not mod by zero) run in the
//   bit-serial shared adder unit between execute and result. The two
//   register reads go through the single RAM read port in turn. One
//   instruction is in flight; the next word is taken once the current
//   result sits in the output register.
//   Reset clears mode, the send counter, the last sound and the valid bit
//   of every register entry, so all registers read zero at once.
//   When the receiver stalls, the result is held in the output register and
//   a finished following instruction waits in its last state.
// ---------------------------------------------------------------------------
`default_nettype none

module duet_instruction_execute_unit #(
    parameter int REGISTER_COUNT = duet_pkg::DEFAULT_REGISTER_COUNT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire duet_pkg::duet_in_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output duet_pkg::duet_out_t                      m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [duet_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [duet_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import duet_pkg::*;

    localparam int         AW = $clog2(REGISTER_COUNT);
    localparam logic [5:0] RC = 6'(REGISTER_COUNT);

    duet_state_t state_reg, state_next;
    duet_in_t    item_reg, item_next;
    duet_out_t   res_reg, res_next;
    duet_out_t   m_data_reg, m_data_next;
    logic        m_valid_reg, m_valid_next;
    logic        mode_reg, mode_next;
    logic [63:0] last_sound_reg, last_sound_next;
    logic [31:0] sends_done_reg, sends_done_next;
    logic [63:0] xv_reg, xv_next;
    logic [REGISTER_COUNT-1:0] rf_valid_reg, rf_valid_next;

    logic          x_in_range, y_in_range;
    logic [AW-1:0] x_addr, y_addr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;
    logic [63:0]   rd_val, yval, jx;
    logic          cfg_wr;

    duet_alu_ctrl_t alu_ctrl;
    duet_alu_stat_t alu_stat;
    logic [63:0]    alu_result;

    assign x_in_range = ({1'b0, item_reg.x_reg} < RC);
    assign y_in_range = ({1'b0, item_reg.y_reg} < RC);
    assign x_addr     = item_reg.x_reg[AW-1:0];
    assign y_addr     = item_reg.y_reg[AW-1:0];
    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    duet_ram #(
        .WIDTH (64),
        .DEPTH (REGISTER_COUNT)
    ) u_rf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    duet_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (alu_ctrl),
        .a       (xv_reg),
        .b       (yval),
        .stat    (alu_stat),
        .result  (alu_result)
    );

    // register read data, entries never written read as zero
    always_comb begin
        rd_val = '0;
        if (state_reg == ST_RD_Y) begin
            if (x_in_range && rf_valid_reg[x_addr]) begin
                rd_val = ram_rdata;
            end
        end else if (y_in_range && rf_valid_reg[y_addr]) begin
            rd_val = ram_rdata;
        end
        if (item_reg.y_is_reg) begin
            yval = (state_reg == ST_RD_Y) ? 64'd0 : rd_val;
        end else begin
            yval = {{32{item_reg.y_imm[31]}}, item_reg.y_imm};
        end
        jx = item_reg.x_is_reg ? xv_reg : {{32{item_reg.x_imm[31]}}, item_reg.x_imm};
    end

    // sequencer, next state and outputs
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg;
        mode_next       = mode_reg;
        last_sound_next = last_sound_reg;
        sends_done_next = sends_done_reg;
        xv_next         = xv_reg;
        rf_valid_next   = rf_valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = x_addr;
        ram_wdata       = yval;
        ram_raddr       = x_addr;
        alu_ctrl        = '0;

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_wr) begin
            unique case (cfg_index)
                CFG_MODE: begin
                    mode_next = cfg_data[0];
                end
                CFG_CORE_ID: begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(REG_P);
                    ram_wdata = 64'(cfg_data);
                    rf_valid_next[REG_P] = 1'b1;
                end
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_RD_X;
                end
            end
            ST_RD_X: begin
                state_next = ST_RD_Y;
            end
            ST_RD_Y: begin
                xv_next    = rd_val;
                ram_raddr  = y_addr;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                res_next            = '0;
                res_next.pc_delta   = 64'sd1;
                state_next          = ST_RESULT;
                case (item_reg.operation)
                    OP_SET: begin
                        ram_we    = x_in_range;
                        ram_wdata = yval;
                    end
                    OP_ADD: begin
                        ram_we    = x_in_range;
                        ram_wdata = xv_reg + yval;
                    end
                    OP_MUL: begin
                        alu_ctrl.start = 1'b1;
                        state_next     = ST_ALU;
                    end
                    OP_MOD: begin
                        if (yval == 64'd0) begin
                            res_next.fault = 1'b1;
                        end else begin
                            alu_ctrl.start  = 1'b1;
                            alu_ctrl.is_mod = 1'b1;
                            state_next      = ST_ALU;
                        end
                    end
                    OP_JGZ: begin
                        if (jx != 64'd0 && !jx[63]) begin
                            res_next.pc_delta = yval;
                        end
                    end
                    OP_SND: begin
                        if (!mode_reg) begin
                            last_sound_next = yval;
                        end else begin
                            res_next.send_valid = 1'b1;
                            res_next.send_value = yval;
                            if (sends_done_reg != '1) begin
                                sends_done_next = sends_done_reg + 32'd1;
                            end
                        end
                    end
                    OP_RCV: begin
                        if (!mode_reg) begin
                            if (xv_reg != 64'd0 && !xv_reg[63]) begin
                                res_next.recovered       = 1'b1;
                                res_next.recovered_value = last_sound_reg;
                            end
                        end else if (item_reg.receive_valid) begin
                            ram_we                 = x_in_range;
                            ram_wdata              = item_reg.receive_value;
                            res_next.receive_taken = 1'b1;
                        end else begin
                            res_next.waiting  = 1'b1;
                            res_next.pc_delta = '0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (ram_we) begin
                    rf_valid_next[x_addr] = 1'b1;
                end
                res_next.send_count = sends_done_next;
            end
            ST_ALU: begin
                if (alu_stat.done) begin
                    ram_we     = x_in_range;
                    ram_wdata  = alu_result;
                    if (x_in_range) begin
                        rf_valid_next[x_addr] = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            mode_reg       <= 1'b0;
            last_sound_reg <= '0;
            sends_done_reg <= '0;
            rf_valid_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            mode_reg       <= mode_next;
            last_sound_reg <= last_sound_next;
            sends_done_reg <= sends_done_next;
            rf_valid_reg   <= rf_valid_next;
        end
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        xv_reg     <= xv_next;
    end

`ifndef ASSERT_OFF
    a_alu_start_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_ctrl.start |-> state_reg == ST_EXEC) else $error("alu started outside exec");
    a_alu_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_stat.done |-> state_reg == ST_ALU) else $error("alu result with no waiter");
    a_wait_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.waiting |-> m_data_reg.pc_delta == 64'sd0)
        else $error("wait with nonzero step");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_EXEC |=> sends_done_reg == $past(sends_done_reg))
        else $error("send count moved outside exec");
`endif

endmodule

`default_nettype wire

// ----- verif/duet_checker.sv -----
// ---------------------------------------------------------------------------
// duet_checker
// Watches the instruction, config and result channels of the execute unit,
// keeps its own copy of the register file and compares every result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module duet_checker
    import duet_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  duet_in_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  duet_out_t              m_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     error_count,
    output int                     pending_count
);

    localparam int NREG   = DEFAULT_REGISTER_COUNT;
    localparam int QDEPTH = 16;

    logic [63:0] reg_file [NREG];
    logic [63:0] sound;
    logic [31:0] sent;
    logic        msg_mode;
    duet_out_t   exp_mem [QDEPTH];
    int          wr_ptr = 0;
    int          rd_ptr = 0;

    assign pending_count = wr_ptr - rd_ptr;

    function automatic logic [63:0] read_reg(input logic [4:0] idx);
        if (idx < NREG) return reg_file[idx];
        return 64'd0;
    endfunction

    function automatic logic is_pos(input logic [63:0] v);
        return v != 0 && !v[63];
    endfunction

    // truncating remainder, sign follows the dividend
    function automatic logic [63:0] rem_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma, mb, r;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        r  = ma % mb;
        return a[63] ? -r : r;
    endfunction

    // execute one instruction word on the shadow state
    task automatic execute_word(input duet_in_t w);
        duet_out_t   r;
        logic [63:0] xv, yv, dv;
        logic        wr_en;
        xv = w.x_is_reg ? read_reg(w.x_reg) : {{32{w.x_imm[31]}}, w.x_imm};
        yv = w.y_is_reg ? read_reg(w.y_reg) : {{32{w.y_imm[31]}}, w.y_imm};
        r = '0;
        r.pc_delta = 64'sd1;
        wr_en = 1'b0;
        dv = '0;
        case (w.operation)
            OP_SET: begin wr_en = 1; dv = yv; end
            OP_ADD: begin wr_en = 1; dv = read_reg(w.x_reg) + yv; end
            OP_MUL: begin wr_en = 1; dv = read_reg(w.x_reg) * yv; end
            OP_MOD: begin
                if (yv == 0) r.fault = 1;
                else begin wr_en = 1; dv = rem_trunc(read_reg(w.x_reg), yv); end
            end
            OP_JGZ: if (is_pos(xv)) r.pc_delta = yv;
            OP_SND: begin
                if (!msg_mode) sound = yv;
                else begin
                    r.send_valid = 1;
                    r.send_value = yv;
                    if (sent != 32'hFFFF_FFFF) sent++;
                end
            end
            OP_RCV: begin
                if (!msg_mode) begin
                    if (is_pos(read_reg(w.x_reg))) begin
                        r.recovered = 1;
                        r.recovered_value = sound;
                    end
                end else if (w.receive_valid) begin
                    wr_en = 1; dv = w.receive_value; r.receive_taken = 1;
                end else begin
                    r.waiting = 1; r.pc_delta = '0;
                end
            end
            default: ;
        endcase
        if (wr_en && w.x_reg < NREG) reg_file[w.x_reg] = dv;
        r.send_count = sent;
        exp_mem[wr_ptr % QDEPTH] = r;
        wr_ptr++;
    endtask

    always @(posedge aclk) begin
        duet_out_t e;
        if (!aresetn) begin
            for (int i = 0; i < NREG; i++) reg_file[i] = '0;
            sound = '0;
            sent = '0;
            msg_mode = 0;
            wr_ptr = 0;
            rd_ptr = 0;
            error_count <= 0;
        end else begin
            // config writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MODE) msg_mode = cfg_data[0];
                else if (cfg_index == CFG_CORE_ID) reg_file[REG_P] = {56'd0, cfg_data};
            end
            // compare result word
            if (m_valid && m_ready) begin
                if (wr_ptr == rd_ptr) begin
                    $display("%0t: unexpected result word %h", $time, m_data);
                    error_count <= error_count + 1;
                end else begin
                    e = exp_mem[rd_ptr % QDEPTH];
                    rd_ptr++;
                    if (e !== m_data) begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, m_data);
                        if (e.pc_delta !== m_data.pc_delta)
                            $display("  pc_delta exp %h got %h", e.pc_delta, m_data.pc_delta);
                        if (e.send_value !== m_data.send_value || e.send_valid !== m_data.send_valid)
                            $display("  send exp %b/%h got %b/%h", e.send_valid, e.send_value,
                                     m_data.send_valid, m_data.send_value);
                        if (e.recovered_value !== m_data.recovered_value)
                            $display("  recovered_value exp %h got %h", e.recovered_value,
                                     m_data.recovered_value);
                        if (e.send_count !== m_data.send_count)
                            $display("  send_count exp %h got %h", e.send_count,
                                     m_data.send_count);
                        if ({e.receive_taken, e.waiting, e.recovered, e.fault} !==
                            {m_data.receive_taken, m_data.waiting, m_data.recovered, m_data.fault})
                            $display("  flags exp %b%b%b%b got %b%b%b%b", e.receive_taken,
                                     e.waiting, e.recovered, e.fault, m_data.receive_taken,
                                     m_data.waiting, m_data.recovered, m_data.fault);
                        error_count <= error_count + 1;
                    end
                end
            end
            // accepted instruction word
            if (s_valid && s_ready) execute_word(s_data);
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Drives directed and random instruction words into the duet execute unit
// across mode and core_id settings with random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import duet_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int NREGS    = DEFAULT_REGISTER_COUNT;
    localparam int IN_W     = $bits(duet_in_t);

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid, s_ready;
    duet_in_t               s_data;
    logic                   m_valid, m_ready;
    duet_out_t              m_data;
    logic                   cfg_valid, cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     error_count, pending_count;
    int                     send_idle, recv_idle;
    int                     stall_cycles;

    duet_instruction_execute_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    duet_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // receiver stalls at random
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // send one instruction word, with a random gap first
    task automatic send_word(input duet_in_t w);
        while ($urandom_range(99) < send_idle) @(posedge aclk);
        s_valid <= 1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // let all results drain, then the longest latency again
    task automatic drain();
        while (pending_count != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic duet_in_t make_word(input logic [2:0] op, input logic xr,
                                           input logic [4:0] xi, input logic [31:0] xm,
                                           input logic yr, input logic [4:0] yi,
                                           input logic [31:0] ym, input logic rv,
                                           input logic [63:0] rval);
        duet_in_t w;
        w.operation = op; w.x_is_reg = xr; w.x_reg = xi; w.x_imm = xm;
        w.y_is_reg = yr; w.y_reg = yi; w.y_imm = ym;
        w.receive_valid = rv; w.receive_value = rval;
        return w;
    endfunction

    // random word, registers mostly in range, values often at extremes
    function automatic duet_in_t rand_word();
        duet_in_t w;
        logic [31:0] pick [4];
        w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        pick[0] = 32'h8000_0000; pick[1] = 32'h7FFF_FFFF; pick[2] = 32'hFFFF_FFFF;
        pick[3] = $urandom_range(7);
        w.operation = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(6));
        if ($urandom_range(19) != 0) w.x_reg = 5'($urandom_range(NREGS - 1));
        if ($urandom_range(19) != 0) w.y_reg = 5'($urandom_range(NREGS - 1));
        if ($urandom_range(2) == 0) w.y_imm = pick[$urandom_range(3)];
        if ($urandom_range(2) == 0) w.x_imm = pick[$urandom_range(3)];
        if ($urandom_range(3) == 0) w.receive_value = {$urandom_range(1) ? 32'h8000_0000 :
                                                       32'h7FFF_FFFF, 32'($urandom)};
        return w;
    endfunction

    initial begin
        aresetn = 0;
        s_valid = 0; s_data = '0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        send_idle = 24; recv_idle = 45;
        stall_cycles = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: sound mode, core_id at maximum
        write_cfg(CFG_CORE_ID, 8'hFF);
        send_word(make_word(OP_SET, 0, 5'd0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
        send_word(make_word(OP_ADD, 0, 5'd0, 0, 1, 5'd15, 0, 0, 0));
        send_word(make_word(OP_MUL, 0, 5'd0, 0, 0, 0, 32'h8000_0000, 0, 0));
        send_word(make_word(OP_SET, 0, 5'd1, 0, 0, 0, 32'h8000_0000, 0, 0));
        send_word(make_word(OP_MUL, 0, 5'd1, 0, 1, 5'd1, 0, 0, 0));
        send_word(make_word(OP_MUL, 0, 5'd1, 0, 0, 0, 32'h8000_0000, 0, 0));
        send_word(make_word(OP_SET, 0, 5'd2, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));
        send_word(make_word(OP_MOD, 0, 5'd1, 0, 1, 5'd2, 0, 0, 0));
        send_word(make_word(OP_MOD, 0, 5'd0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_MOD, 0, 5'd15, 0, 0, 0, 32'hFFFF_FFF9, 0, 0));
        send_word(make_word(OP_SET, 0, 5'd31, 0, 0, 0, 32'd9, 0, 0));
        send_word(make_word(OP_ADD, 0, 5'd3, 0, 1, 5'd31, 0, 0, 0));
        send_word(make_word(OP_JGZ, 1, 5'd15, 0, 0, 0, 32'hFFFF_FFFD, 0, 0));
        send_word(make_word(OP_JGZ, 0, 5'd0, 32'h8000_0000, 0, 0, 32'd5, 0, 0));
        send_word(make_word(OP_JGZ, 0, 5'd0, 32'h7FFF_FFFF, 1, 5'd0, 0, 0, 0));
        send_word(make_word(OP_SND, 0, 5'd0, 0, 0, 0, 32'd42, 0, 0));
        send_word(make_word(OP_RCV, 0, 5'd15, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_RCV, 0, 5'd1, 0, 0, 0, 0, 1, 64'd7));
        send_word(make_word(3'd7, 1, 5'd31, 32'hFFFF_FFFF, 1, 5'd31, 32'hFFFF_FFFF, 1, '1));
        drain();

        // directed: message mode, core_id zero
        write_cfg(CFG_MODE, 8'd1);
        write_cfg(CFG_CORE_ID, 8'd0);
        send_word(make_word(OP_SND, 0, 5'd0, 0, 1, 5'd15, 0, 0, 0));
        send_word(make_word(OP_RCV, 0, 5'd4, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_RCV, 0, 5'd4, 0, 0, 0, 0, 1, 64'h8000_0000_0000_0000));
        send_word(make_word(OP_RCV, 0, 5'd30, 0, 0, 0, 0, 1, 64'h7FFF_FFFF_FFFF_FFFF));
        send_word(make_word(OP_MOD, 0, 5'd4, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));
        drain();

        // random phases across settings and idling patterns
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle = 45; recv_idle = 24; end
            if (ph == 4) begin send_idle = 0; recv_idle = 0; end
            write_cfg(CFG_MODE, 8'(ph % 2));
            write_cfg(CFG_CORE_ID, (ph == 3) ? 8'hFF : 8'($urandom_range(255)));
            for (int n = 0; n < 170; n++) send_word(rand_word());
            drain();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
